### design/psrb_pkg.sv
// psrb_pkg: shared types and fixed constants of the shift-reduce binarizer.
// No dependencies; used by the front, back and top level.
package psrb_pkg;

    localparam int VAR_W          = 8;   // variable number and base width
    localparam int BLK_W          = 6;   // source block count width
    localparam int OUT_POS_W      = 4;   // position width on the result port
    localparam int STK_DEPTH      = 16;  // span stack depth
    localparam int STK_CNT_W      = 5;   // holds 0..STK_DEPTH
    localparam int STK_IDX_W      = 4;   // indexes 0..STK_DEPTH-1
    localparam int MIN_SRC_BLOCKS = 3;

    localparam logic [VAR_W-1:0] VAR_BASE_RESET = 8'd1;

    localparam logic KIND_MERGE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Classification flags of one queued word.
    typedef struct packed {
        logic oor;      // variable number out of range, not pushed
        logic last;     // last variable of the rule
        logic blk_ok;   // source block count high enough
        logic cnt_bad;  // too many variables in this rule so far
    } t_flags;

endpackage

### design/permutation_shift_reduce_binarizer.sv
// permutation_shift_reduce_binarizer: top level of the shift-reduce binarizer.
// Depends on psrb_pkg, psrb_front, psrb_queue and psrb_back.
//
// Usage
//   Input channel (i_valid / o_ready): one word per target-side variable of
//   a rule, in target order. i_last_var marks the last variable; the source
//   block count is only looked at on that word.
//   Output channel (o_valid / i_ready): one merge record per reduction, then
//   after the last variable a verdict word (o_kind = 1). o_last_result flags
//   the final word caused by an input word.
//   Config: i_cfg_wr_en / i_cfg_wr_data writes var_base (reset 1); write only
//   while the block is idle.
// Sequencing
//   The front classifies and counts in the accept cycle and writes a
//   two-entry queue. The back sequencer pushes a word in its idle state,
//   then in its reduce state does one merge per step plus one closing check,
//   then gives the verdict after the last word; it takes no new word until it
//   is idle again. Each merge pops one span from the stack. A merge record is
//   held until the next reduce step decides last_result, and then enters the
//   output register once that register is free.
// Reset and stall
//   Synchronous active-low reset empties the stack, queue and counters; the
//   stack storage itself is not cleared. If i_ready stays low the output
//   register holds, the back stalls, the queue fills and o_ready drops.
module permutation_shift_reduce_binarizer
    import psrb_pkg::*;
#(
    parameter int MAX_VARS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [VAR_W-1:0]     i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [VAR_W-1:0]     i_var_number,
    input  logic [BLK_W-1:0]     i_src_block_count,
    input  logic                 i_last_var,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_kind,
    output logic [OUT_POS_W-1:0] o_span_begin,
    output logic [OUT_POS_W-1:0] o_span_end,
    output logic [OUT_POS_W-1:0] o_split_end,
    output logic                 o_inverted,
    output logic                 o_binarizable,
    output logic                 o_error,
    output logic                 o_last_result
);

    localparam int POS_W = $clog2(MAX_VARS);      // positions 0..MAX_VARS-1
    localparam int VC_W  = $clog2(MAX_VARS + 2);  // var count 0..MAX_VARS+1
    localparam int QW    = POS_W + VC_W + $bits(t_flags);

    logic             f_valid;
    logic             f_ready;
    logic [POS_W-1:0] f_pos;
    logic [VC_W-1:0]  f_vcnt;
    t_flags           f_flags;

    logic             b_valid;
    logic             b_ready;
    logic [QW-1:0]    b_data;
    logic [POS_W-1:0] b_pos;
    logic [VC_W-1:0]  b_vcnt;
    t_flags           b_flags;

    psrb_front #(
        .MAX_VARS (MAX_VARS),
        .POS_W    (POS_W),
        .VC_W     (VC_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_var_number      (i_var_number),
        .i_src_block_count (i_src_block_count),
        .i_last_var        (i_last_var),
        .o_q_valid         (f_valid),
        .i_q_ready         (f_ready),
        .o_pos             (f_pos),
        .o_vcnt            (f_vcnt),
        .o_flags           (f_flags)
    );

    psrb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  ({f_flags, f_vcnt, f_pos}),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd_data  (b_data)
    );

    assign {b_flags, b_vcnt, b_pos} = b_data;

    psrb_back #(
        .POS_W (POS_W),
        .VC_W  (VC_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (b_valid),
        .o_q_ready     (b_ready),
        .i_pos         (b_pos),
        .i_vcnt        (b_vcnt),
        .i_flags       (b_flags),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_span_begin  (o_span_begin),
        .o_span_end    (o_span_end),
        .o_split_end   (o_split_end),
        .o_inverted    (o_inverted),
        .o_binarizable (o_binarizable),
        .o_error       (o_error),
        .o_last_result (o_last_result)
    );

endmodule

### design/psrb_front.sv
// psrb_front: accepts input words, range-checks and counts variables.
// Depends on psrb_pkg; feeds psrb_queue.
module psrb_front
    import psrb_pkg::*;
#(
    parameter int MAX_VARS = 16,
    parameter int POS_W    = 4,
    parameter int VC_W     = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [VAR_W-1:0]    i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [VAR_W-1:0]    i_var_number,
    input  logic [BLK_W-1:0]    i_src_block_count,
    input  logic                i_last_var,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output logic [POS_W-1:0]    o_pos,
    output logic [VC_W-1:0]     o_vcnt,
    output t_flags              o_flags
);

    logic [VAR_W-1:0] r_var_base;
    logic [VC_W-1:0]  r_vcnt;
    logic [VC_W-1:0]  n_vcnt;
    logic [VAR_W:0]   diff;

    assign o_ready   = i_q_ready;
    assign o_q_valid = i_valid;

    assign diff = {1'b0, i_var_number} - {1'b0, r_var_base};

    // count saturates one past the limit; anything beyond is bad anyway
    assign n_vcnt = (r_vcnt < VC_W'(MAX_VARS + 1)) ? r_vcnt + VC_W'(1) : r_vcnt;

    assign o_pos            = diff[POS_W-1:0];
    assign o_vcnt           = n_vcnt;
    assign o_flags.oor      = diff[VAR_W] || (diff[VAR_W-1:0] >= VAR_W'(MAX_VARS));
    assign o_flags.last     = i_last_var;
    assign o_flags.blk_ok   = i_src_block_count >= BLK_W'(MIN_SRC_BLOCKS);
    assign o_flags.cnt_bad  = n_vcnt > VC_W'(MAX_VARS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_base <= VAR_BASE_RESET;
            r_vcnt     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_var_base <= i_cfg_wr_data;
            end
            if (i_valid && i_q_ready) begin
                r_vcnt <= i_last_var ? '0 : n_vcnt;
            end
        end
    end

endmodule

### design/psrb_queue.sv
// psrb_queue: two-entry word queue between front and back.
// No dependencies.
module psrb_queue #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             wr;
    logic             rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (wr) begin
                r_mem[r_wr_ptr] <= i_wr_data;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/psrb_back.sv
// psrb_back: span stack, reduction sequencer and output register.
// Depends on psrb_pkg; reads words from psrb_queue.
module psrb_back
    import psrb_pkg::*;
#(
    parameter int POS_W = 4,
    parameter int VC_W  = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [VC_W-1:0]      i_vcnt,
    input  t_flags               i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_kind,
    output logic [OUT_POS_W-1:0] o_span_begin,
    output logic [OUT_POS_W-1:0] o_span_end,
    output logic [OUT_POS_W-1:0] o_split_end,
    output logic                 o_inverted,
    output logic                 o_binarizable,
    output logic                 o_error,
    output logic                 o_last_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RED  = 2'd1;
    localparam logic [1:0] ST_VERD = 2'd2;
    localparam int EW = ((POS_W > VC_W) ? POS_W : VC_W) + 1;

    logic [1:0]           r_state;
    logic [STK_CNT_W-1:0] r_cnt;
    logic                 r_bad;
    logic [POS_W-1:0]     r_stk_beg [STK_DEPTH];
    logic [POS_W-1:0]     r_stk_end [STK_DEPTH];
    logic [POS_W-1:0]     r_top_beg;
    logic [POS_W-1:0]     r_top_end;
    logic [VC_W-1:0]      r_vcnt;
    logic                 r_last;
    logic                 r_blk_ok;

    // merge record held back until we know whether it is the last one
    logic                 r_pend_v;
    logic [POS_W-1:0]     r_pend_beg;
    logic [POS_W-1:0]     r_pend_end;
    logic [POS_W-1:0]     r_pend_split;
    logic                 r_pend_inv;

    logic                 r_o_valid;
    logic                 r_o_kind;
    logic [OUT_POS_W-1:0] r_o_beg;
    logic [OUT_POS_W-1:0] r_o_end;
    logic [OUT_POS_W-1:0] r_o_split;
    logic                 r_o_inv;
    logic                 r_o_bin;
    logic                 r_o_err;
    logic                 r_o_last;

    logic [STK_CNT_W-1:0] cnt_m1;
    logic [STK_CNT_W-1:0] cnt_m2;
    logic [STK_IDX_W-1:0] wr_idx;
    logic [STK_IDX_W-1:0] rd_idx;
    logic [POS_W-1:0]     lo_beg;
    logic [POS_W-1:0]     lo_end;
    logic                 adj_str;
    logic                 adj_inv;
    logic                 can_merge;
    logic [POS_W-1:0]     m_beg;
    logic [POS_W-1:0]     m_end;
    logic [POS_W-1:0]     m_split;
    logic                 out_free;
    logic                 out_load;
    logic                 verdict;

    assign cnt_m1 = r_cnt - STK_CNT_W'(1);
    assign cnt_m2 = r_cnt - STK_CNT_W'(2);
    assign wr_idx = cnt_m1[STK_IDX_W-1:0];
    assign rd_idx = cnt_m2[STK_IDX_W-1:0];
    assign lo_beg = r_stk_beg[rd_idx];
    assign lo_end = r_stk_end[rd_idx];

    assign adj_str   = (EW'(lo_end) + EW'(1)) == EW'(r_top_beg);
    assign adj_inv   = (EW'(r_top_end) + EW'(1)) == EW'(lo_beg);
    assign can_merge = (r_cnt > STK_CNT_W'(1)) && (adj_str || adj_inv);
    assign m_beg     = adj_str ? lo_beg : r_top_beg;
    assign m_end     = adj_str ? r_top_end : lo_end;
    assign m_split   = adj_str ? lo_end : r_top_end;

    assign out_free  = !r_o_valid || i_ready;
    // output register takes a new word this cycle
    assign out_load  = ((r_state == ST_RED) && r_pend_v && out_free) ||
                       ((r_state == ST_VERD) && out_free);
    assign o_q_ready = (r_state == ST_IDLE);

    assign verdict = !r_bad && (r_cnt == STK_CNT_W'(1)) && (r_top_beg == '0) &&
                     ((EW'(r_top_end) + EW'(1)) == EW'(r_vcnt)) && r_blk_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_bad     <= 1'b0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !out_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_vcnt   <= i_vcnt;
                        r_last   <= i_flags.last;
                        r_blk_ok <= i_flags.blk_ok;
                        if (i_flags.oor || (r_cnt >= STK_CNT_W'(STK_DEPTH)) ||
                            i_flags.cnt_bad) begin
                            r_bad <= 1'b1;
                        end
                        if (!i_flags.oor && (r_cnt < STK_CNT_W'(STK_DEPTH))) begin
                            if (r_cnt != '0) begin
                                r_stk_beg[wr_idx] <= r_top_beg;
                                r_stk_end[wr_idx] <= r_top_end;
                            end
                            r_top_beg <= i_pos;
                            r_top_end <= i_pos;
                            r_cnt     <= r_cnt + STK_CNT_W'(1);
                        end
                        r_state <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            r_o_valid <= 1'b1;
                            r_o_kind  <= KIND_MERGE;
                            r_o_beg   <= OUT_POS_W'(r_pend_beg);
                            r_o_end   <= OUT_POS_W'(r_pend_end);
                            r_o_split <= OUT_POS_W'(r_pend_split);
                            r_o_inv   <= r_pend_inv;
                            r_o_bin   <= 1'b0;
                            r_o_err   <= 1'b0;
                            r_o_last  <= !can_merge && !r_last;
                        end
                        if (can_merge) begin
                            r_top_beg    <= m_beg;
                            r_top_end    <= m_end;
                            r_cnt        <= cnt_m1;
                            r_pend_v     <= 1'b1;
                            r_pend_beg   <= m_beg;
                            r_pend_end   <= m_end;
                            r_pend_split <= m_split;
                            r_pend_inv   <= !adj_str;
                        end else begin
                            r_pend_v <= 1'b0;
                            r_state  <= r_last ? ST_VERD : ST_IDLE;
                        end
                    end
                end
                ST_VERD: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= KIND_VERDICT;
                        r_o_beg   <= '0;
                        r_o_end   <= '0;
                        r_o_split <= '0;
                        r_o_inv   <= 1'b0;
                        r_o_bin   <= verdict;
                        r_o_err   <= r_bad;
                        r_o_last  <= 1'b1;
                        r_cnt     <= '0;
                        r_bad     <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_span_begin  = r_o_beg;
    assign o_span_end    = r_o_end;
    assign o_split_end   = r_o_split;
    assign o_inverted    = r_o_inv;
    assign o_binarizable = r_o_bin;
    assign o_error       = r_o_err;
    assign o_last_result = r_o_last;

endmodule

### design/psrb_checker.sv
// psrb_checker: port-level assertions on the binarizer's result channel.
// Depends on psrb_pkg; bound to permutation_shift_reduce_binarizer.
module psrb_checker
    import psrb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic                 o_kind,
    input logic [OUT_POS_W-1:0] o_span_begin,
    input logic [OUT_POS_W-1:0] o_span_end,
    input logic [OUT_POS_W-1:0] o_split_end,
    input logic                 o_inverted,
    input logic                 o_binarizable,
    input logic                 o_error,
    input logic                 o_last_result
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) &&
            $stable(o_span_begin) && $stable(o_span_end) && $stable(o_split_end) &&
            $stable(o_inverted) && $stable(o_last_result) &&
            $stable(o_binarizable) && $stable(o_error))
        else $error("result changed while stalled");

    // a verdict always closes its input word
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_VERDICT) |-> o_last_result)
        else $error("verdict without last_result");

    a_merge_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_MERGE) |-> !o_binarizable && !o_error)
        else $error("merge record carries verdict bits");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_VERDICT) |->
            (o_span_begin == '0) && (o_span_end == '0) && (o_split_end == '0) && !o_inverted)
        else $error("verdict carries span bits");

    // an error verdict is never binarizable
    a_err_not_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> !o_binarizable)
        else $error("binarizable with error");

endmodule

bind permutation_shift_reduce_binarizer psrb_checker u_psrb_checker (.*);
